// File: rtl/ccwb_pkg.sv
// Shared types and constants for the color cube weighted blend.
package ccwb_pkg;

    localparam int PORT_COUNT       = 6;
    localparam int MAX_SOURCES      = 6;
    localparam int MAX_EDGE         = 64;
    localparam int BLOCK_TEXELS     = 16;
    localparam int WEIGHT_FRAC_BITS = 14;

    localparam int CELL_W    = 24;
    localparam int CHAN_W    = 8;
    localparam int CHANNELS  = 3;
    localparam int WEIGHT_W  = 16;
    localparam int PROD_W    = CHAN_W + WEIGHT_W;
    localparam int SUM_W     = PROD_W + $clog2(PORT_COUNT);
    localparam int COORD_W   = 6;
    localparam int EDGE_W    = 7;
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int TEXEL_W   = 32;
    localparam int IN_DATA_W  = PORT_COUNT * CELL_W;
    localparam int OUT_DATA_W = 56;

    localparam logic [CHAN_W-1:0]   CHANNEL_MAX  = 8'hFF;
    localparam logic [CHAN_W-1:0]   ALPHA_OPAQUE = 8'hFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(1 << WEIGHT_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_COUNT = 3'd0,
        REG_EDGE_SIZE    = 3'd1,
        REG_WEIGHT_A     = 3'd2,
        REG_WEIGHT_B     = 3'd3,
        REG_WEIGHT_C     = 3'd4,
        REG_WEIGHT_D     = 3'd5,
        REG_WEIGHT_E     = 3'd6,
        REG_WEIGHT_F     = 3'd7
    } cfg_reg_t;

    typedef logic [PROD_W-1:0] lane_prod_t [CHANNELS];

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               done;
    } coord_t;

endpackage

// File: rtl/ccwb_lane.sv
// One blend lane: scales the three channels of one source cell by its weight.
module ccwb_lane (
    input  logic                           aclk,
    input  logic                           load,
    input  logic [ccwb_pkg::CELL_W-1:0]    src_texel,
    input  logic [ccwb_pkg::WEIGHT_W-1:0]  weight,
    output ccwb_pkg::lane_prod_t           prod
);
    import ccwb_pkg::*;

    lane_prod_t prod_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                prod_reg[ch] <= PROD_W'(src_texel[ch*CHAN_W +: CHAN_W]) * PROD_W'(weight);
            end
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/ccwb_scan.sv
// Scan counters: x, y, z position of each destination texel, registered per request.
module ccwb_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ccwb_pkg::EDGE_W-1:0]   edge_size,
    input  logic                          step,
    output logic                          live,
    output ccwb_pkg::coord_t              coord
);
    import ccwb_pkg::*;

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] slc_reg, slc_next;
    coord_t             coord_reg;
    logic [EDGE_W-1:0]  edge_eff;
    logic [EDGE_W-1:0]  row_len;
    logic               last_x, last_y, last_z;

    always_comb begin
        edge_eff = (edge_size > EDGE_W'(MAX_EDGE)) ? EDGE_W'(MAX_EDGE) : edge_size;
        row_len  = edge_eff & ~EDGE_W'(BLOCK_TEXELS - 1);
        live     = (row_len != '0);
        last_x   = ({1'b0, col_reg} + EDGE_W'(1)) >= row_len;
        last_y   = ({1'b0, row_reg} + EDGE_W'(1)) >= edge_eff;
        last_z   = ({1'b0, slc_reg} + EDGE_W'(1)) >= edge_eff;

        col_next = col_reg;
        row_next = row_reg;
        slc_next = slc_reg;
        if (step) begin
            if (!last_x) begin
                col_next = col_reg + COORD_W'(1);
            end else begin
                col_next = '0;
                if (!last_y) begin
                    row_next = row_reg + COORD_W'(1);
                end else begin
                    row_next = '0;
                    slc_next = last_z ? '0 : slc_reg + COORD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            slc_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            slc_reg <= slc_next;
        end
    end

    // capture the position of the request as it enters the lanes
    always_ff @(posedge aclk) begin
        if (step) begin
            coord_reg.x    <= col_reg;
            coord_reg.y    <= row_reg;
            coord_reg.z    <= slc_reg;
            coord_reg.done <= last_x && last_y && last_z;
        end
    end

    assign coord = coord_reg;

endmodule

// File: rtl/ccwb_merge.sv
// Merge stage: sums the lane products, truncates, clamps and holds the result.
module ccwb_merge (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  ccwb_pkg::lane_prod_t                     prod [ccwb_pkg::PORT_COUNT],
    input  ccwb_pkg::coord_t                         coord,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [ccwb_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic                                     m_tlast
);
    import ccwb_pkg::*;

    logic                   valid_reg, valid_next;
    logic [TEXEL_W-1:0]     texel_reg;
    coord_t                 coord_reg;
    logic [SUM_W-1:0]       sum   [CHANNELS];
    logic [CHAN_W-1:0]      chan  [CHANNELS];
    logic                   load;

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            sum[ch] = '0;
            for (int k = 0; k < PORT_COUNT; k++) begin
                sum[ch] = sum[ch] + SUM_W'(prod[k][ch]);
            end
            chan[ch] = (sum[ch][SUM_W-1:WEIGHT_FRAC_BITS] > (SUM_W - WEIGHT_FRAC_BITS)'(CHANNEL_MAX))
                     ? CHANNEL_MAX : sum[ch][WEIGHT_FRAC_BITS +: CHAN_W];
        end
    end

    assign in_ready = !valid_reg || m_tready;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // red sits at cell byte 0, blue at byte 2; the texel word swaps them
    always_ff @(posedge aclk) begin
        if (load) begin
            texel_reg <= {ALPHA_OPAQUE, chan[0], chan[1], chan[2]};
            coord_reg <= coord;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = coord_reg.done;
    assign m_tdata  = OUT_DATA_W'({coord_reg.z, coord_reg.y, coord_reg.x, texel_reg});

endmodule

// File: rtl/color_cube_weighted_blend.sv
// Top level of the color cube weighted blend: config registers, lanes, scan, merge.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: cell_a..cell_f
//  m_      | out       | m_tvalid/m_tready  | m_tdata: texel, x, y, z; m_tlast: cube_done
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle unless s_tready is low; six lanes multiply into their product
// registers, then the merge adder tree, shift and clamp feed the output register.
// Reset clears the scan counters, the pipeline valids and loads the register defaults.
// A stalled output only blocks input once the lane stage is full as well.
// Requests that yield no texel are taken and dropped without moving the counters.
module color_cube_weighted_blend (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_a [23:0], cell_b [47:24], cell_c, cell_d, cell_e, cell_f [143:120]
    input  logic [ccwb_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // texel_word [31:0], coord_x [37:32], coord_y [43:38], coord_z [49:44], zero [55:50]
    output logic [ccwb_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccwb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccwb_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import ccwb_pkg::*;

    logic [COUNT_W-1:0]  source_count_reg;
    logic [EDGE_W-1:0]   edge_size_reg;
    logic [WEIGHT_W-1:0] weight_reg [PORT_COUNT];
    logic [WEIGHT_W-1:0] weight_eff [PORT_COUNT];

    logic       lane_valid_reg, lane_valid_next;
    logic       merge_ready;
    logic       accept, produce, src_ok, live, copy_mode;
    coord_t     coord;
    lane_prod_t prod [PORT_COUNT];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_count_reg <= COUNT_W'(1);
            edge_size_reg    <= EDGE_W'(32);
            for (int k = 0; k < PORT_COUNT; k++) begin
                weight_reg[k] <= (k == 0) ? WEIGHT_ONE : '0;
            end
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_SOURCE_COUNT: source_count_reg <= cfg_data[COUNT_W-1:0];
                REG_EDGE_SIZE:    edge_size_reg    <= cfg_data[EDGE_W-1:0];
                REG_WEIGHT_A:     weight_reg[0]    <= cfg_data;
                REG_WEIGHT_B:     weight_reg[1]    <= cfg_data;
                REG_WEIGHT_C:     weight_reg[2]    <= cfg_data;
                REG_WEIGHT_D:     weight_reg[3]    <= cfg_data;
                REG_WEIGHT_E:     weight_reg[4]    <= cfg_data;
                REG_WEIGHT_F:     weight_reg[5]    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign src_ok    = (source_count_reg != '0) && (source_count_reg <= COUNT_W'(MAX_SOURCES));
    assign copy_mode = (source_count_reg == COUNT_W'(1));
    assign s_tready  = !lane_valid_reg || merge_ready;
    assign accept    = s_tvalid && s_tready;
    assign produce   = accept && src_ok && live;

    // plain copy runs lane 0 at unit weight and mutes the rest
    always_comb begin
        for (int k = 0; k < PORT_COUNT; k++) begin
            if (copy_mode) begin
                weight_eff[k] = (k == 0) ? WEIGHT_ONE : '0;
            end else begin
                weight_eff[k] = (COUNT_W'(k) < source_count_reg) ? weight_reg[k] : '0;
            end
        end
    end

    always_comb begin
        lane_valid_next = lane_valid_reg;
        if (s_tready) begin
            lane_valid_next = produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg <= 1'b0;
        end else begin
            lane_valid_reg <= lane_valid_next;
        end
    end

    for (genvar k = 0; k < PORT_COUNT; k++) begin : g_lane
        ccwb_lane u_lane (
            .aclk      (aclk),
            .load      (produce),
            .src_texel (s_tdata[k*CELL_W +: CELL_W]),
            .weight    (weight_eff[k]),
            .prod      (prod[k])
        );
    end

    ccwb_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .edge_size (edge_size_reg),
        .step      (produce),
        .live      (live),
        .coord     (coord)
    );

    ccwb_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (lane_valid_reg),
        .in_ready (merge_ready),
        .prod     (prod),
        .coord    (coord),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/ccwb_check.sv
// Port-level checks for the color cube weighted blend, bound to the top level.
module ccwb_check (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ccwb_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import ccwb_pkg::*;

    // hold a stalled result
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:24] == ALPHA_OPAQUE)
        else $error("alpha byte not opaque");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:50] == '0)
        else $error("pad bits not zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind color_cube_weighted_blend ccwb_check u_ccwb_check (.*);

// File: bench/color_cube_weighted_blend_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the color cube weighted blend: scan walk, random blends, flow control.
module color_cube_weighted_blend_tb;
    import ccwb_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int WALK_CHUNK    = 256;
    localparam int WALK_ROUNDS   = 2;
    localparam int PHASE_ITEMS   = 800;

    typedef struct packed {
        logic [TEXEL_W-1:0] word;
        coord_t             pos;
    } texel_rec_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    // predicted register file and scan position
    logic [COUNT_W-1:0]  blend_sources;
    logic [EDGE_W-1:0]   cube_edge;
    logic [WEIGHT_W-1:0] blend_weight [PORT_COUNT];
    int unsigned         col_pos   = 0;
    int unsigned         row_pos   = 0;
    int unsigned         slice_pos = 0;

    logic [IN_DATA_W-1:0] cell_queue [$];
    texel_rec_t           texel_expect [$];

    logic        s_taken        = 1'b0;
    bit          steady_flow    = 1'b0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    int unsigned texels_seen    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    color_cube_weighted_blend dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic bit blend_texel(input logic [IN_DATA_W-1:0] cells,
                                       output texel_rec_t rec);
        int unsigned       span;
        int unsigned       row_len;
        int unsigned       acc;
        int                ch;
        int                k;
        logic [CHAN_W-1:0] rgb [CHANNELS];
        bit                last_x;
        bit                last_y;
        bit                last_z;
        rec = '0;
        if (blend_sources == 0 || blend_sources > MAX_SOURCES)
            return 1'b0;
        span    = (cube_edge > MAX_EDGE) ? MAX_EDGE : cube_edge;
        row_len = (span / BLOCK_TEXELS) * BLOCK_TEXELS;
        if (row_len == 0)
            return 1'b0;
        for (ch = 0; ch < CHANNELS; ch++) begin
            if (blend_sources == 1) begin
                rgb[ch] = cells[ch*CHAN_W +: CHAN_W];
            end else begin
                acc = 0;
                for (k = 0; k < blend_sources; k++)
                    acc += cells[k*CELL_W + ch*CHAN_W +: CHAN_W] * blend_weight[k];
                acc = acc >> WEIGHT_FRAC_BITS;
                rgb[ch] = (acc > CHANNEL_MAX) ? CHANNEL_MAX : acc[CHAN_W-1:0];
            end
        end
        last_x = (col_pos + 1 >= row_len);
        last_y = (row_pos + 1 >= span);
        last_z = (slice_pos + 1 >= span);
        rec.word     = {ALPHA_OPAQUE, rgb[0], rgb[1], rgb[2]};
        rec.pos.x    = col_pos[COORD_W-1:0];
        rec.pos.y    = row_pos[COORD_W-1:0];
        rec.pos.z    = slice_pos[COORD_W-1:0];
        rec.pos.done = last_x && last_y && last_z;
        // an out-of-bound counter still reports, then wraps on the advance
        if (!last_x) begin
            col_pos = (col_pos + 1) % (1 << COORD_W);
        end else begin
            col_pos = 0;
            if (!last_y) begin
                row_pos = (row_pos + 1) % (1 << COORD_W);
            end else begin
                row_pos = 0;
                if (!last_z)
                    slice_pos = (slice_pos + 1) % (1 << COORD_W);
                else
                    slice_pos = 0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] value);
        case (cfg_reg_t'(idx))
            REG_SOURCE_COUNT: blend_sources = value[COUNT_W-1:0];
            REG_EDGE_SIZE:    cube_edge     = value[EDGE_W-1:0];
            default:          blend_weight[idx - REG_WEIGHT_A] = value;
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_cells();
        logic [IN_DATA_W-1:0] cells;
        int                   k;
        for (k = 0; k < PORT_COUNT; k++) begin
            case ($urandom_range(0, 15))
                0:       cells[k*CELL_W +: CELL_W] = '0;
                1:       cells[k*CELL_W +: CELL_W] = '1;
                default: cells[k*CELL_W +: CELL_W] = CELL_W'($urandom());
            endcase
        end
        return cells;
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return WEIGHT_ONE;
            3, 4:    return WEIGHT_W'($urandom_range(0, 16'h2FFF));
            default: return WEIGHT_W'($urandom());
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %0s at texel %0d: got 0x%0h, want 0x%0h",
                 what, texels_seen, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued request is taken and every texel has come back.
    task automatic settle_block();
        do @(posedge aclk);
        while (cell_queue.size() != 0 || s_tvalid || texel_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Request driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (cell_queue.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 32)) begin
                s_tdata  <= cell_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off to back the block up.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && texels_seen >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= steady_flow || ($urandom_range(0, 99) >= 32);
        end
    end

    // Predict on every accepted request, check every accepted texel.
    always @(posedge aclk) begin
        texel_rec_t want;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                if (blend_texel(s_tdata, want))
                    texel_expect.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                texels_seen++;
                if (texel_expect.size() == 0) begin
                    flag_mismatch("texel with nothing pending", m_tdata[TEXEL_W-1:0], '0);
                end else begin
                    want = texel_expect.pop_front();
                    if (m_tdata[TEXEL_W-1:0] !== want.word)
                        flag_mismatch("texel_word", m_tdata[TEXEL_W-1:0], want.word);
                    if (m_tdata[TEXEL_W +: COORD_W] !== want.pos.x)
                        flag_mismatch("coord_x", 32'(m_tdata[TEXEL_W +: COORD_W]),
                                      32'(want.pos.x));
                    if (m_tdata[TEXEL_W+COORD_W +: COORD_W] !== want.pos.y)
                        flag_mismatch("coord_y", 32'(m_tdata[TEXEL_W+COORD_W +: COORD_W]),
                                      32'(want.pos.y));
                    if (m_tdata[TEXEL_W+2*COORD_W +: COORD_W] !== want.pos.z)
                        flag_mismatch("coord_z", 32'(m_tdata[TEXEL_W+2*COORD_W +: COORD_W]),
                                      32'(want.pos.z));
                    if (m_tdata[OUT_DATA_W-1:TEXEL_W+3*COORD_W] !== '0)
                        flag_mismatch("tdata padding",
                                      32'(m_tdata[OUT_DATA_W-1:TEXEL_W+3*COORD_W]), '0);
                    if (m_tlast !== want.pos.done)
                        flag_mismatch("cube_done", 32'(m_tlast), 32'(want.pos.done));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned          pushed;
        int unsigned          n;
        int                   k;
        bit                   live;
        logic [CFG_DAT_W-1:0] word;
        blend_sources = 3'd1;
        cube_edge     = 7'd32;
        for (k = 0; k < PORT_COUNT; k++)
            blend_weight[k] = '0;
        blend_weight[0] = WEIGHT_ONE;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // copy mode at reset defaults: cell_a passes, the other cells are ignored
        cell_queue.push_back({{5{24'hA5C3E1}}, 24'h000000});
        cell_queue.push_back({{5{24'h000000}}, 24'hFFFFFF});
        cell_queue.push_back({6{24'hAAAAAA}});
        cell_queue.push_back({6{24'h555555}});
        settle_block();

        // six sources at full weight saturate, zero cells stay zero
        write_reg(REG_SOURCE_COUNT, 16'd6);
        for (k = 0; k < PORT_COUNT; k++)
            write_reg(cfg_reg_t'(REG_WEIGHT_A + k), '1);
        cell_queue.push_back({6{24'hFFFFFF}});
        cell_queue.push_back('0);
        settle_block();
        for (k = 0; k < PORT_COUNT; k++)
            write_reg(cfg_reg_t'(REG_WEIGHT_A + k), '0);
        cell_queue.push_back({6{24'hFFFFFF}});
        settle_block();

        // two sources; cells past the count must not leak in
        write_reg(REG_SOURCE_COUNT, 16'd2);
        write_reg(REG_WEIGHT_A, WEIGHT_ONE);
        write_reg(REG_WEIGHT_B, 16'h7FFF);
        cell_queue.push_back({{4{24'hFFFFFF}}, 24'h102030, 24'h0A0B0C});
        cell_queue.push_back(random_cells());
        settle_block();

        // copy mode ignores its weight
        write_reg(REG_SOURCE_COUNT, 16'd1);
        write_reg(REG_WEIGHT_A, '0);
        cell_queue.push_back(random_cells());
        settle_block();

        // skipped source counts: nothing comes out and the scan holds
        write_reg(REG_SOURCE_COUNT, 16'd0);
        repeat (2) cell_queue.push_back(random_cells());
        settle_block();
        write_reg(REG_SOURCE_COUNT, 16'hFFFF);
        repeat (2) cell_queue.push_back(random_cells());
        settle_block();

        // rows shorter than one block drop, oversize edges clamp
        write_reg(REG_SOURCE_COUNT, 16'd3);
        write_reg(REG_EDGE_SIZE, 16'd0);
        cell_queue.push_back(random_cells());
        settle_block();
        write_reg(REG_EDGE_SIZE, 16'd15);
        cell_queue.push_back(random_cells());
        settle_block();
        write_reg(REG_EDGE_SIZE, 16'hFF7F);
        repeat (2) cell_queue.push_back(random_cells());
        settle_block();
        write_reg(REG_EDGE_SIZE, 16'd64);
        cell_queue.push_back(random_cells());
        settle_block();
        write_reg(REG_EDGE_SIZE, 16'd16);
        repeat (2) cell_queue.push_back(random_cells());
        settle_block();

        // walk the smallest cube across row and slice wraps, re-weighting between chunks
        word = CFG_DAT_W'($urandom());
        word[EDGE_W-1:0] = 7'd16;
        write_reg(REG_EDGE_SIZE, word);
        n = 0;
        while (n < WALK_ROUNDS) begin
            settle_block();
            steady_flow = (n == WALK_ROUNDS - 1);
            word = CFG_DAT_W'($urandom());
            word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, MAX_SOURCES));
            write_reg(REG_SOURCE_COUNT, word);
            for (k = 0; k < PORT_COUNT; k++)
                write_reg(cfg_reg_t'(REG_WEIGHT_A + k), random_weight());
            repeat (WALK_CHUNK) cell_queue.push_back(random_cells());
            n++;
        end
        settle_block();

        pushed = 0;
        while (pushed < PHASE_ITEMS) begin
            settle_block();
            steady_flow = ($urandom_range(0, 5) == 0);
            live = 1'b1;
            word = CFG_DAT_W'($urandom());
            case ($urandom_range(0, 9))
                0:       begin word[COUNT_W-1:0] = 3'd0; live = 1'b0; end
                1:       begin word[COUNT_W-1:0] = 3'd7; live = 1'b0; end
                default: word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, MAX_SOURCES));
            endcase
            write_reg(REG_SOURCE_COUNT, word);
            word = CFG_DAT_W'($urandom());
            case ($urandom_range(0, 9))
                0:       begin word[EDGE_W-1:0] = EDGE_W'($urandom_range(0, 15)); live = 1'b0; end
                1:       word[EDGE_W-1:0] = EDGE_W'($urandom_range(65, 127));
                2:       word[EDGE_W-1:0] = 7'd16;
                3:       word[EDGE_W-1:0] = 7'd64;
                default: word[EDGE_W-1:0] = EDGE_W'($urandom_range(16, 64));
            endcase
            write_reg(REG_EDGE_SIZE, word);
            for (k = 0; k < PORT_COUNT; k++)
                write_reg(cfg_reg_t'(REG_WEIGHT_A + k), random_weight());
            n = $urandom_range(30, 150);
            repeat (n) cell_queue.push_back(random_cells());
            if (live)
                pushed += n;
        end
        settle_block();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
